[hw/rtl/llmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// llmq_pkg: shared types, constants and microprogram for the linked-list queues
// Holds the request and status codes, the control word layout, the microcode
// ROM and the dispatch that picks the first step of each request.
// ----------------------------------------------------------------------------
package llmq_pkg;

  localparam int NODES_DEF  = 64;
  localparam int QUEUES_DEF = 4;
  localparam int TYPE_W     = 2;
  localparam int QID_W      = 2;
  localparam int NODE_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int UPC_W      = 5;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_SPLICE = 2'd2,
    REQ_PEEK   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAME  = 2'd2
  } st_e;

  // Tail memory read address
  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_Q    = 2'd1,
    TR_S    = 2'd2
  } tr_e;

  // Link memory read address
  typedef enum logic [1:0] {
    LR_NONE = 2'd0,
    LR_TAIL = 2'd1,
    LR_LINK = 2'd2
  } lr_e;

  // Link memory write address
  typedef enum logic [1:0] {
    LA_ND   = 2'd0,
    LA_TAIL = 2'd1,
    LA_H    = 2'd2,
    LA_T    = 2'd3
  } la_e;

  // Link memory write data
  typedef enum logic [1:0] {
    WD_ND   = 2'd0,
    WD_LINK = 2'd1,
    WD_H    = 2'd2
  } wd_e;

  // Tail memory write data (address is always the target queue)
  typedef enum logic [1:0] {
    TW_NONE = 2'd0,
    TW_ND   = 2'd1,
    TW_TAIL = 2'd2
  } tw_e;

  typedef enum logic [1:0] {
    JC_NONE = 2'd0,
    JC_PEEK = 2'd1,
    JC_SAME = 2'd2
  } jc_e;

  typedef enum logic [UPC_W-1:0] {
    U_R_OK     = 5'd0,
    U_R_EMPTY  = 5'd1,
    U_R_SAME   = 5'd2,
    U_ENQ_NEW  = 5'd3,
    U_ENQ_0    = 5'd4,
    U_ENQ_1    = 5'd5,
    U_ENQ_2    = 5'd6,
    U_ENQ_3    = 5'd7,
    U_DEQ_0    = 5'd8,
    U_DEQ_1    = 5'd9,
    U_DEQ_2    = 5'd10,
    U_DEQ_3    = 5'd11,
    U_DEQ_4    = 5'd12,
    U_DEQ_5    = 5'd13,
    U_DEQ_LAST = 5'd14,
    U_SPL_0    = 5'd15,
    U_SPL_1    = 5'd16,
    U_SPL_2    = 5'd17,
    U_SPL_3    = 5'd18,
    U_SPL_4    = 5'd19,
    U_SPN_0    = 5'd20,
    U_SPN_1    = 5'd21
  } upc_e;

  typedef struct packed {
    tr_e   tr;
    lr_e   lr;
    logic  lw_en;
    la_e   la;
    wd_e   wd;
    tw_e   tw;
    logic  vset_q;
    logic  vclr_q;
    logic  vclr_s;
    logic  ld_t;
    logic  ld_h;
    logic  ld_res;
    jc_e   jc;
    upc_e  jt;
    logic  done;
    st_e   status;
  } ucw_t;

  // Request facts sampled at the input, used for dispatch
  typedef struct packed {
    logic qok;
    logic ndok;
    logic vq;
    logic has_s;
    logic same;
  } disp_t;

  // Datapath conditions tested by the sequencer
  typedef struct packed {
    logic peek;
    logic same_ht;
  } flags_t;

  function automatic upc_e ucode_entry(req_e op, disp_t d);
    upc_e e;
    e = U_R_OK;
    unique case (op)
      REQ_ENQ: begin
        if (!(d.qok && d.ndok)) e = U_R_OK;
        else if (d.vq)          e = U_ENQ_0;
        else                    e = U_ENQ_NEW;
      end
      REQ_DEQ, REQ_PEEK: begin
        e = d.vq ? U_DEQ_0 : U_R_EMPTY;
      end
      REQ_SPLICE: begin
        priority if (d.same)             e = U_R_SAME;
        else if (!(d.qok && d.has_s))    e = U_R_OK;
        else if (d.vq)                   e = U_SPL_0;
        else                             e = U_SPN_0;
      end
    endcase
    return e;
  endfunction

  function automatic ucw_t ucode(upc_e a);
    ucw_t w;
    w = '0;
    unique case (a)
      U_R_OK:    begin w.done = 1'b1; w.status = ST_OK; end
      U_R_EMPTY: begin w.done = 1'b1; w.status = ST_EMPTY; end
      U_R_SAME:  begin w.done = 1'b1; w.status = ST_SAME; end
      U_ENQ_NEW: begin
        w.lw_en = 1'b1; w.la = LA_ND; w.wd = WD_ND;
        w.tw = TW_ND; w.vset_q = 1'b1; w.done = 1'b1;
      end
      U_ENQ_0: begin w.tr = TR_Q; end
      U_ENQ_1: begin w.lr = LR_TAIL; end
      U_ENQ_2: begin w.lw_en = 1'b1; w.la = LA_ND; w.wd = WD_LINK; end
      U_ENQ_3: begin
        w.lw_en = 1'b1; w.la = LA_TAIL; w.wd = WD_ND;
        w.tw = TW_ND; w.done = 1'b1;
      end
      U_DEQ_0: begin w.tr = TR_Q; end
      U_DEQ_1: begin w.lr = LR_TAIL; end
      U_DEQ_2: begin
        w.ld_h = 1'b1; w.ld_res = 1'b1; w.lr = LR_LINK;
        w.jc = JC_PEEK; w.jt = U_R_OK;
      end
      U_DEQ_3: begin w.jc = JC_SAME; w.jt = U_DEQ_LAST; end
      U_DEQ_4: begin w.lw_en = 1'b1; w.la = LA_TAIL; w.wd = WD_LINK; end
      U_DEQ_5: begin
        w.lw_en = 1'b1; w.la = LA_H; w.wd = WD_H; w.done = 1'b1;
      end
      U_DEQ_LAST: begin w.vclr_q = 1'b1; w.done = 1'b1; end
      U_SPL_0: begin w.tr = TR_Q; end
      U_SPL_1: begin w.tr = TR_S; w.lr = LR_TAIL; w.ld_t = 1'b1; end
      U_SPL_2: begin w.ld_h = 1'b1; w.lr = LR_TAIL; end
      U_SPL_3: begin w.lw_en = 1'b1; w.la = LA_T; w.wd = WD_LINK; end
      U_SPL_4: begin
        w.lw_en = 1'b1; w.la = LA_TAIL; w.wd = WD_H; w.tw = TW_TAIL;
        w.vset_q = 1'b1; w.vclr_s = 1'b1; w.done = 1'b1;
      end
      U_SPN_0: begin w.tr = TR_S; end
      U_SPN_1: begin
        w.tw = TW_TAIL; w.vset_q = 1'b1; w.vclr_s = 1'b1; w.done = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/llmq_useq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// llmq_useq: microcode sequencer
// Step counter over the microcode ROM, entry dispatch per request and
// conditional jumps; the done step waits for the result register to be free.
// ----------------------------------------------------------------------------
module llmq_useq
  import llmq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  input  wire req_e   op_i,
  input  wire disp_t  disp_i,
  input  wire flags_t flags_i,
  input  wire logic   out_free_i,
  output      logic   busy_o,
  output      logic   done_o,
  output      ucw_t   ctrl_o
);

  logic busy_q, busy_d;
  upc_e step_q, step_d;
  ucw_t rom_w;
  logic fire;
  logic jump_hit;

  assign rom_w = ucode(step_q);
  assign fire  = busy_q && (!rom_w.done || out_free_i);

  always_comb begin
    unique case (rom_w.jc)
      JC_PEEK: jump_hit = flags_i.peek;
      JC_SAME: jump_hit = flags_i.same_ht;
      default: jump_hit = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (accept_i) begin
      busy_d = 1'b1;
      step_d = ucode_entry(op_i, disp_i);
    end else if (fire) begin
      if (rom_w.done) begin
        busy_d = 1'b0;
      end else if (jump_hit) begin
        step_d = rom_w.jt;
      end else begin
        step_d = upc_e'(UPC_W'(step_q) + UPC_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= U_R_OK;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Suppress all side effects while idle or held at a blocked done step
  assign ctrl_o = fire ? rom_w : '0;
  assign done_o = fire && rom_w.done;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

[hw/rtl/llmq_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// llmq_dp: queue datapath
// Link and tail memories with registered reads, queue valid bits, request
// and scratch registers, and the link memory clearing pass after reset.
// ----------------------------------------------------------------------------
module llmq_dp
  import llmq_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int QUEUES = QUEUES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire req_e              op_i,
  input  wire logic [QID_W-1:0]  queue_id_i,
  input  wire logic [QID_W-1:0]  source_queue_i,
  input  wire logic [NODE_W-1:0] node_i,
  input  wire ucw_t              ctrl_i,
  output      disp_t             disp_o,
  output      flags_t            flags_o,
  output      logic [NODE_W-1:0] res_node_o,
  output      logic              tgt_empty_o,
  output      logic              clearing_o
);

  localparam int NW = $clog2(NODES);
  localparam int QW = $clog2(QUEUES);

  logic [NW-1:0] link_mem [NODES];
  logic [NW-1:0] tail_mem [QUEUES];

  logic [QUEUES-1:0] valid_q, valid_d;

  req_e          op_q;
  logic [QW-1:0] q_q, s_q;
  logic          qok_q;
  logic [NW-1:0] nd_q;
  logic [NW-1:0] t_q, h_q, res_node_q;
  logic [NW-1:0] tail_rd_q, link_rd_q;

  logic          clr_q;
  logic [NW-1:0] clr_cnt_q;

  logic [QW-1:0] q_in, s_in;
  logic          qok_in, sok_in;

  logic [QW-1:0] tr_addr;
  logic [NW-1:0] tw_data;
  logic [NW-1:0] lr_addr;
  logic          lw_en;
  logic [NW-1:0] lw_addr, lw_data;

  // Request facts for dispatch, straight from the input fields
  assign q_in   = QW'(queue_id_i);
  assign s_in   = QW'(source_queue_i);
  assign qok_in = 32'(queue_id_i) < 32'(QUEUES);
  assign sok_in = 32'(source_queue_i) < 32'(QUEUES);

  assign disp_o.qok   = qok_in;
  assign disp_o.ndok  = 32'(node_i) < 32'(NODES);
  assign disp_o.vq    = qok_in && valid_q[q_in];
  assign disp_o.has_s = sok_in && valid_q[s_in];
  assign disp_o.same  = queue_id_i == source_queue_i;

  assign flags_o.peek    = op_q == REQ_PEEK;
  assign flags_o.same_ht = h_q == tail_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q       <= op_i;
      q_q        <= q_in;
      s_q        <= s_in;
      qok_q      <= qok_in;
      nd_q       <= NW'(node_i);
      res_node_q <= '0;
    end else if (ctrl_i.ld_res) begin
      res_node_q <= link_rd_q;
    end
    if (ctrl_i.ld_t) t_q <= tail_rd_q;
    if (ctrl_i.ld_h) h_q <= link_rd_q;
  end

  // Tail memory
  always_comb begin
    unique case (ctrl_i.tr)
      TR_S:    tr_addr = s_q;
      default: tr_addr = q_q;
    endcase
    unique case (ctrl_i.tw)
      TW_TAIL: tw_data = tail_rd_q;
      default: tw_data = nd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tw != TW_NONE) tail_mem[q_q] <= tw_data;
    if (ctrl_i.tr != TR_NONE) tail_rd_q <= tail_mem[tr_addr];
  end

  // Link memory; the clearing pass owns the write port until it ends
  always_comb begin
    unique case (ctrl_i.lr)
      LR_LINK: lr_addr = link_rd_q;
      default: lr_addr = tail_rd_q;
    endcase
    unique case (ctrl_i.la)
      LA_ND:   lw_addr = nd_q;
      LA_TAIL: lw_addr = tail_rd_q;
      LA_H:    lw_addr = h_q;
      LA_T:    lw_addr = t_q;
    endcase
    unique case (ctrl_i.wd)
      WD_LINK: lw_data = link_rd_q;
      WD_H:    lw_data = h_q;
      default: lw_data = nd_q;
    endcase
    lw_en = ctrl_i.lw_en;
    if (clr_q) begin
      lw_en   = 1'b1;
      lw_addr = clr_cnt_q;
      lw_data = clr_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    if (ctrl_i.lr != LR_NONE) link_rd_q <= link_mem[lr_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + NW'(1);
      if (clr_cnt_q == NW'(NODES - 1)) clr_q <= 1'b0;
    end
  end

  // Queue valid bits
  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.vset_q) valid_d[q_q] = 1'b1;
    if (ctrl_i.vclr_q) valid_d[q_q] = 1'b0;
    if (ctrl_i.vclr_s) valid_d[s_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign tgt_empty_o = !(qok_q && valid_d[q_q]);
  assign res_node_o  = NODE_W'(res_node_q);
  assign clearing_o  = clr_q;

endmodule
`default_nettype wire

[hw/rtl/linked_list_multi_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linked_list_multi_queue: FIFO queues sharing one pool of linked nodes
// Each queue is a circular singly linked list known by its tail node.
// Requests enqueue, dequeue, splice a whole queue, or peek at the head.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_* channel (valid/stall); each one gives exactly
//   one result on the out_* channel (valid/stall), in order.
//   One request is worked at a time by a microcode sequencer, in a run of
//   steps that depends on the request type and on which queues are empty.
//   The link memory has one read port, one write port and a registered
//   read: every link lookup and every link update takes a step of its own.
//   The result appears in the output register the cycle after the final
//   step. in_stall_o is high while a request is in work.
//   After reset the link memory is swept so that each node points to itself;
//   in_stall_o is held high during the sweep.
//   If out_stall_i holds a result, the next request may still be accepted
//   and worked; its final step waits until the output register frees up.
// ----------------------------------------------------------------------------
module linked_list_multi_queue
  import llmq_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int QUEUES = QUEUES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [TYPE_W-1:0]   req_type_i,
  input  wire logic [QID_W-1:0]    queue_id_i,
  input  wire logic [QID_W-1:0]    source_queue_i,
  input  wire logic [NODE_W-1:0]   node_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [NODE_W-1:0]   node_out_o,
  output      logic [STATUS_W-1:0] status_o,
  output      logic                target_empty_o
);

  logic   accept;
  logic   busy, done, clearing;
  logic   out_free;
  req_e   op;
  disp_t  disp;
  flags_t flags;
  ucw_t   ctrl;
  logic [NODE_W-1:0] res_node;
  logic   tgt_empty;

  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] node_out_q;
  st_e               status_q;
  logic              te_q;

  assign op         = req_e'(req_type_i);
  assign in_stall_o = busy || clearing;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  llmq_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op),
    .disp_i     (disp),
    .flags_i    (flags),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .ctrl_o     (ctrl)
  );

  llmq_dp #(
    .NODES  (NODES),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op),
    .queue_id_i     (queue_id_i),
    .source_queue_i (source_queue_i),
    .node_i         (node_i),
    .ctrl_i         (ctrl),
    .disp_o         (disp),
    .flags_o        (flags),
    .res_node_o     (res_node),
    .tgt_empty_o    (tgt_empty),
    .clearing_o     (clearing)
  );

  // Output register: load on the final step, drop once the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (done)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      node_out_q <= res_node;
      status_q   <= ctrl.status;
      te_q       <= tgt_empty;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign node_out_o     = node_out_q;
  assign status_o       = status_q;
  assign target_empty_o = te_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer not busy after an accepted request");

  a_done_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled result");

  a_idle_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_q)
    else $error("request finished without a result");

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !busy)
    else $error("request in work during the link clearing pass");

endmodule
`default_nettype wire

[verif/linked_list_multi_queue_tb.sv]
// ----------------------------------------------------------------------------
// linked_list_multi_queue_tb: self-checking bench for the shared-pool queues
// Plays a directed opening and then mostly well-formed random traffic into the
// four queues. A model of the links, tails and occupancy flags predicts every
// result, and the bench compares each result with its prediction in order.
// The sender runs in bursts and the receiver stalls, both at random.
// ----------------------------------------------------------------------------
module linked_list_multi_queue_tb;
  import llmq_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1825;
  localparam int SETTLE_CYCLES = 16;
  localparam int NO_NODE       = -1;

  typedef struct packed {
    req_e              op;
    logic [QID_W-1:0]  qid;
    logic [QID_W-1:0]  src;
    logic [NODE_W-1:0] node;
    logic              drain_first;
  } request_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    st_e               status;
    logic              empty;
  } result_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_SPARSE,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_mode_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [TYPE_W-1:0]   req_type  = '0;
  logic [QID_W-1:0]    queue_id  = '0;
  logic [QID_W-1:0]    src_queue = '0;
  logic [NODE_W-1:0]   node_in   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [NODE_W-1:0]   node_out;
  logic [STATUS_W-1:0] status;
  logic                target_empty;

  // Model of the link pool
  logic [NODE_W-1:0] link_of  [NODES_DEF];
  logic [NODE_W-1:0] tail_of  [QUEUES_DEF];
  logic              occupied [QUEUES_DEF];

  // Rough shadow of queue contents, used only to shape the stimulus
  logic [NODE_W-1:0] plan_fifo [QUEUES_DEF][NODES_DEF];
  int                plan_head [QUEUES_DEF];
  int                plan_cnt  [QUEUES_DEF];
  bit                plan_used [NODES_DEF];

  request_t request_backlog[$];
  result_t  awaited_results[$];
  int       failures = 0;

  linked_list_multi_queue uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .queue_id_i     (queue_id),
    .source_queue_i (src_queue),
    .node_i         (node_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .node_out_o     (node_out),
    .status_o       (status),
    .target_empty_o (target_empty)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic result_t update_lists(request_t r);
    result_t           res;
    logic [NODE_W-1:0] t;
    logic [NODE_W-1:0] h;
    logic [NODE_W-1:0] swap;
    res.node   = '0;
    res.status = ST_OK;
    res.empty  = 1'b0;
    case (r.op)
      REQ_ENQ: begin
        if (!occupied[r.qid]) begin
          link_of[r.node]  = r.node;
          occupied[r.qid] = 1'b1;
        end else begin
          t               = tail_of[r.qid];
          link_of[r.node] = link_of[t];
          link_of[t]      = r.node;
        end
        tail_of[r.qid] = r.node;
      end
      REQ_DEQ, REQ_PEEK: begin
        if (!occupied[r.qid]) begin
          res.status = ST_EMPTY;
        end else begin
          t        = tail_of[r.qid];
          h        = link_of[t];
          res.node = h;
          if (r.op == REQ_DEQ) begin
            if (h == t) begin
              occupied[r.qid] = 1'b0;
            end else begin
              link_of[t] = link_of[h];
              link_of[h] = h;
            end
          end
        end
      end
      default: begin
        if (r.src == r.qid) begin
          res.status = ST_SAME;
        end else if (occupied[r.src]) begin
          // swap the successors of both tails to join the two rings
          if (occupied[r.qid]) begin
            t                   = tail_of[r.qid];
            swap                = link_of[t];
            link_of[t]          = link_of[tail_of[r.src]];
            link_of[tail_of[r.src]] = swap;
          end
          tail_of[r.qid]  = tail_of[r.src];
          occupied[r.qid] = 1'b1;
          occupied[r.src] = 1'b0;
        end
      end
    endcase
    res.empty = !occupied[r.qid];
    return res;
  endfunction

  function automatic void plan_put(int q, int nd);
    if (plan_cnt[q] < NODES_DEF) begin
      plan_fifo[q][(plan_head[q] + plan_cnt[q]) % NODES_DEF] = nd[NODE_W-1:0];
      plan_cnt[q]++;
    end
    plan_used[nd] = 1'b1;
  endfunction

  function automatic int plan_take(int q);
    int nd;
    nd           = plan_fifo[q][plan_head[q]];
    plan_head[q] = (plan_head[q] + 1) % NODES_DEF;
    plan_cnt[q]--;
    return nd;
  endfunction

  function automatic void plan_request(req_e op, int q, int s, int nd, bit drain);
    request_t r;
    r.op          = op;
    r.qid         = q[QID_W-1:0];
    r.src         = s[QID_W-1:0];
    r.node        = nd[NODE_W-1:0];
    r.drain_first = drain;
    request_backlog.push_back(r);
    case (op)
      REQ_ENQ: plan_put(q, nd);
      REQ_DEQ: begin
        if (plan_cnt[q] > 0) plan_used[plan_take(q)] = 1'b0;
      end
      REQ_SPLICE: begin
        if (s != q) begin
          while (plan_cnt[s] > 0) plan_put(q, plan_take(s));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_free(int start);
    for (int k = 0; k < NODES_DEF; k++) begin
      if (!plan_used[(start + k) % NODES_DEF]) return (start + k) % NODES_DEF;
    end
    return NO_NODE;
  endfunction

  function automatic int busy_queue(int start);
    for (int k = 0; k < QUEUES_DEF; k++) begin
      if (plan_cnt[(start + k) % QUEUES_DEF] > 0) return (start + k) % QUEUES_DEF;
    end
    return start;
  endfunction

  initial begin : stimulus
    int  roll;
    int  q;
    int  s;
    int  nd;
    int  spare;
    bit  drain;
    for (int i = 0; i < NODES_DEF; i++) begin
      link_of[i]   = i[NODE_W-1:0];
      plan_used[i] = 1'b0;
    end
    for (int i = 0; i < QUEUES_DEF; i++) begin
      tail_of[i]   = '0;
      occupied[i]  = 1'b0;
      plan_head[i] = 0;
      plan_cnt[i]  = 0;
    end

    plan_request(REQ_PEEK,   0, 3, 63, 1'b0);
    plan_request(REQ_DEQ,    3, 0, 42, 1'b0);
    plan_request(REQ_SPLICE, 1, 1, 21, 1'b0);  // same queue, both empty
    plan_request(REQ_SPLICE, 0, 2,  0, 1'b0);  // empty source
    plan_request(REQ_ENQ,    0, 1,  0, 1'b0);  // into an empty queue
    plan_request(REQ_ENQ,    0, 2, 63, 1'b0);
    plan_request(REQ_ENQ,    0, 3, 21, 1'b0);
    plan_request(REQ_PEEK,   0, 0, 63, 1'b0);
    plan_request(REQ_ENQ,    1, 0, 42, 1'b0);
    plan_request(REQ_ENQ,    1, 3, 10, 1'b0);
    plan_request(REQ_SPLICE, 0, 1, 63, 1'b0);  // onto a non-empty target
    plan_request(REQ_SPLICE, 3, 0,  0, 1'b0);  // onto an empty target
    plan_request(REQ_SPLICE, 3, 3, 42, 1'b0);  // same queue, not empty
    for (int i = 0; i < 5; i++) plan_request(REQ_DEQ, 3, 2, 21, 1'b0);
    plan_request(REQ_ENQ,    2, 1,  5, 1'b0);
    plan_request(REQ_DEQ,    2, 0, 63, 1'b0);  // last node leaves
    plan_request(REQ_ENQ,    1, 2,  7, 1'b0);
    plan_request(REQ_ENQ,    1, 2,  7, 1'b0);  // node already linked
    plan_request(REQ_PEEK,   1, 3,  0, 1'b0);
    plan_request(REQ_DEQ,    1, 0, 42, 1'b0);
    plan_request(REQ_DEQ,    1, 1, 21, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll  = $urandom_range(0, 99);
      q     = $urandom_range(0, 3);
      s     = $urandom_range(0, 3);
      nd    = $urandom_range(0, 63);
      spare = pick_free(nd);
      drain = (n % 600 == 599);
      if (roll < 3) begin
        // relink whatever node comes up, in use or not
        plan_request(REQ_ENQ, q, s, nd, drain);
      end else if (roll < 40 && spare != NO_NODE) begin
        plan_request(REQ_ENQ, q, s, spare, drain);
      end else if (roll < 68) begin
        if ($urandom_range(0, 4) != 0) q = busy_queue(q);
        plan_request(REQ_DEQ, q, s, nd, drain);
      end else if (roll < 82) begin
        s = busy_queue(s);
        if (s == q) q = (s + 1 + $urandom_range(0, 2)) % QUEUES_DEF;
        if ($urandom_range(0, 9) == 0) s = q;
        plan_request(REQ_SPLICE, q, s, nd, drain);
      end else begin
        if ($urandom_range(0, 4) != 0) q = busy_queue(q);
        plan_request(REQ_PEEK, q, s, nd, drain);
      end
    end

    // sample between edges so the driver's updates have settled
    while (request_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Request driver: bursts of transactions separated by random gaps
  request_t on_bus;
  int       burst_left;
  int       gap_left;

  always @(posedge clk or negedge rst_n) begin : drive
    request_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 24);
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) awaited_results.push_back(update_lists(on_bus));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain_first && awaited_results.size() != 0)) begin
          nxt       = request_backlog.pop_front();
          on_bus    <= nxt;
          in_valid  <= 1'b1;
          req_type  <= nxt.op;
          queue_id  <= nxt.qid;
          src_queue <= nxt.src;
          node_in   <= nxt.node;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: switch between stall patterns every so often
  sink_mode_e sink_mode;
  int         mode_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_mode <= SINK_OPEN;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:     out_stall <= 1'b0;
        SINK_SPARSE:   out_stall <= ($urandom_range(0, 2) == 0);
        SINK_HEAVY:    out_stall <= ($urandom_range(0, 4) != 0);
        SINK_PERIODIC: out_stall <= (mode_left % 8 < 3);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: node_out=%0d status=%0d target_empty=%0d",
               node_out, status, target_empty);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (node_out !== want.node) begin
          $error("node_out: expected %0d, got %0d", want.node, node_out);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        if (target_empty !== want.empty) begin
          $error("target_empty: expected %0d, got %0d", want.empty, target_empty);
          failures++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
